/* hdl/ctpp_pkg.sv */
`timescale 1ns / 1ps
package ctpp_pkg;

    localparam int MaxComponentsDefault = 16;

    // Event codes on the result side
    localparam logic [2:0] EV_COMP    = 3'd0;
    localparam logic [2:0] EV_CHUNK   = 3'd1;
    localparam logic [2:0] EV_NAME    = 3'd2;
    localparam logic [2:0] EV_LAST    = 3'd3;
    localparam logic [2:0] EV_PAYLOAD = 3'd4;
    localparam logic [2:0] EV_ACCEPT  = 3'd5;
    localparam logic [2:0] EV_REJECT  = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_HDR_LEN  = 3'd0;
    localparam logic [2:0] REG_NAME     = 3'd1;
    localparam logic [2:0] REG_META     = 3'd2;
    localparam logic [2:0] REG_PAYLOAD  = 3'd3;
    localparam logic [2:0] REG_SEGMENT  = 3'd4;
    localparam logic [2:0] REG_CHUNK    = 3'd5;
    localparam logic [2:0] REG_ENDCHUNK = 3'd6;

    // One result as it travels through the queue
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  index;
        logic [15:0] offset;
        logic [15:0] length;
        logic [31:0] number;
        logic        last;
    } t_event;

    localparam int EventWidth = $bits(t_event);

    // Room for up to four results caused by one byte
    typedef struct packed {
        logic [2:0]   count;
        t_event [3:0] ev;
    } t_bundle;

    typedef struct packed {
        logic [7:0]  hdr_len;
        logic [15:0] name_code;
        logic [15:0] meta_code;
        logic [15:0] payload_code;
        logic [15:0] segment_code;
        logic [15:0] chunk_code;
        logic [15:0] endchunk_code;
    } t_cfg;

endpackage

/* hdl/ctpp_front.sv */
`timescale 1ns / 1ps
// Parser: consumes one byte per cycle while i_take is high, produces a bundle of up to three events.
module ctpp_front #(
    parameter int MAX_COMPONENTS = ctpp_pkg::MaxComponentsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_eop,
    input  ctpp_pkg::t_cfg    i_cfg,
    output ctpp_pkg::t_bundle o_bundle
);

    typedef enum logic [7:0] {
        PH_MSG_HEAD   = 8'b0000_0001,
        PH_TOP_HEAD   = 8'b0000_0010,
        PH_NAME_HEAD  = 8'b0000_0100,
        PH_CHUNK_VAL  = 8'b0000_1000,
        PH_COMP_SKIP  = 8'b0001_0000,
        PH_META_HEAD  = 8'b0010_0000,
        PH_META_NUM   = 8'b0100_0000,
        PH_SKIP_OUTER = 8'b1000_0000
    } t_phase;

    localparam int CntW = $clog2(MAX_COMPONENTS + 1);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [23:0] r_head, n_head;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [15:0] r_outer, n_outer;
    logic [15:0] r_name, n_name;
    logic [15:0] r_inner, n_inner;
    logic [15:0] r_cstart, n_cstart;
    logic [31:0] r_num, n_num;
    logic [CntW-1:0] r_ccnt, n_ccnt;
    logic        r_err, n_err;

    logic [31:0] head_full;
    logic [15:0] typ, len;
    logic        head_done;
    ctpp_pkg::t_bundle bnd;

    assign head_full = {r_head, i_byte};
    assign typ       = head_full[31:16];
    assign len       = head_full[15:0];
    assign head_done = (r_hcnt == 2'd3);

    // Append one event to the bundle
    function automatic ctpp_pkg::t_bundle add_ev(ctpp_pkg::t_bundle b, logic [2:0] k,
            logic [4:0] idx, logic [15:0] off, logic [15:0] ln, logic [31:0] num);
        ctpp_pkg::t_bundle r;
        r = b;
        r.ev[b.count[1:0]] = '{kind: k, index: idx, offset: off, length: ln,
                               number: num, last: 1'b0};
        r.count = b.count + 3'd1;
        return r;
    endfunction

    always_comb begin
        logic [15:0] nrem;
        logic [15:0] orem;
        logic [31:0] acc;
        logic [15:0] irem;
        n_phase  = r_phase;
        n_pos    = r_pos + 16'd1;
        n_head   = head_full[23:0];
        n_hcnt   = r_hcnt;
        n_outer  = r_outer;
        n_name   = r_name;
        n_inner  = r_inner;
        n_cstart = r_cstart;
        n_num    = r_num;
        n_ccnt   = r_ccnt;
        n_err    = r_err;
        bnd      = '0;
        nrem     = r_name - 16'd1;
        orem     = r_outer - 16'd1;
        acc      = {r_num[23:0], i_byte};
        irem     = r_inner - 16'd1;

        if (!r_err) begin
            unique case (r_phase)
                PH_MSG_HEAD: begin
                    n_hcnt = r_hcnt + 2'd1;
                    if (head_done) n_phase = PH_TOP_HEAD;
                end
                PH_TOP_HEAD: begin
                    n_hcnt = r_hcnt + 2'd1;
                    if (r_hcnt == 2'd0) n_cstart = r_pos;
                    if (head_done) begin
                        if (typ == i_cfg.name_code) begin
                            bnd = add_ev(bnd, ctpp_pkg::EV_NAME, 5'd0,
                                         r_cstart + 16'(i_cfg.hdr_len), len + 16'd4, '0);
                            n_name  = len;
                            n_phase = (len == 16'd0) ? PH_TOP_HEAD : PH_NAME_HEAD;
                        end else if (typ == i_cfg.meta_code) begin
                            if (len < 16'd4) begin
                                n_err = 1'b1;
                            end else begin
                                n_outer = len;
                                n_phase = PH_META_HEAD;
                            end
                        end else begin
                            if (typ == i_cfg.payload_code)
                                bnd = add_ev(bnd, ctpp_pkg::EV_PAYLOAD, 5'd0,
                                             r_cstart + 16'd4 + 16'(i_cfg.hdr_len), len, '0);
                            n_outer = len;
                            n_phase = (len == 16'd0) ? PH_TOP_HEAD : PH_SKIP_OUTER;
                        end
                    end
                end
                PH_NAME_HEAD: begin
                    if (r_hcnt == 2'd0 && r_name < 16'd4) begin
                        n_err = 1'b1;
                    end else begin
                        if (r_hcnt == 2'd0) n_cstart = r_pos;
                        n_name = nrem;
                        n_hcnt = r_hcnt + 2'd1;
                        if (head_done) begin
                            if (len > nrem) begin
                                n_err = 1'b1;
                            end else begin
                                n_inner = len;
                                if ((typ == i_cfg.chunk_code || typ == i_cfg.segment_code)
                                    && r_ccnt < CntW'(MAX_COMPONENTS)) begin
                                    bnd = add_ev(bnd, ctpp_pkg::EV_COMP,
                                                 5'(r_ccnt), r_cstart + 16'(i_cfg.hdr_len),
                                                 len + 16'd4, '0);
                                    n_ccnt = r_ccnt + 1'b1;
                                end
                                if (typ == i_cfg.chunk_code) begin
                                    n_num = '0;
                                    if (len == 16'd0) begin
                                        bnd = add_ev(bnd, ctpp_pkg::EV_CHUNK, 5'd0,
                                                     '0, '0, '0);
                                        n_phase = (nrem == 16'd0) ? PH_TOP_HEAD
                                                                  : PH_NAME_HEAD;
                                    end else begin
                                        n_phase = PH_CHUNK_VAL;
                                    end
                                end else if (len == 16'd0) begin
                                    n_phase = (nrem == 16'd0) ? PH_TOP_HEAD : PH_NAME_HEAD;
                                end else begin
                                    n_phase = PH_COMP_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_CHUNK_VAL, PH_COMP_SKIP: begin
                    n_num   = acc;
                    n_inner = irem;
                    n_name  = nrem;
                    if (irem == 16'd0) begin
                        if (r_phase == PH_CHUNK_VAL)
                            bnd = add_ev(bnd, ctpp_pkg::EV_CHUNK, 5'd0, '0, '0, acc);
                        n_phase = (nrem == 16'd0) ? PH_TOP_HEAD : PH_NAME_HEAD;
                    end
                end
                PH_META_HEAD: begin
                    n_outer = orem;
                    n_hcnt  = r_hcnt + 2'd1;
                    if (head_done) begin
                        if (len > orem) begin
                            n_err = 1'b1;
                        end else if (typ == i_cfg.endchunk_code) begin
                            n_num = '0;
                            if (len == 16'd0) begin
                                bnd = add_ev(bnd, ctpp_pkg::EV_LAST, 5'd0, '0, '0, '0);
                                n_phase = (orem == 16'd0) ? PH_TOP_HEAD : PH_SKIP_OUTER;
                            end else begin
                                n_inner = len;
                                n_phase = PH_META_NUM;
                            end
                        end else begin
                            n_phase = (orem == 16'd0) ? PH_TOP_HEAD : PH_SKIP_OUTER;
                        end
                    end
                end
                PH_META_NUM: begin
                    n_num   = acc;
                    n_inner = irem;
                    n_outer = orem;
                    if (irem == 16'd0) begin
                        bnd = add_ev(bnd, ctpp_pkg::EV_LAST, 5'd0, '0, '0, acc);
                        n_phase = (orem == 16'd0) ? PH_TOP_HEAD : PH_SKIP_OUTER;
                    end
                end
                PH_SKIP_OUTER: begin
                    n_outer = orem;
                    n_phase = (orem == 16'd0) ? PH_TOP_HEAD : PH_SKIP_OUTER;
                end
                default: n_err = 1'b1;
            endcase
        end

        // Packet end: verdict and restart
        if (i_eop) begin
            bnd = add_ev(bnd, (!n_err && n_phase == PH_TOP_HEAD && n_hcnt == 2'd0)
                              ? ctpp_pkg::EV_ACCEPT : ctpp_pkg::EV_REJECT,
                         5'd0, '0, '0, '0);
            n_phase = PH_MSG_HEAD; n_pos = '0; n_head = '0; n_hcnt = '0;
            n_outer = '0; n_name = '0; n_inner = '0; n_cstart = '0;
            n_num = '0; n_ccnt = '0; n_err = 1'b0;
        end
        if (bnd.count != 3'd0) bnd.ev[bnd.count[1:0] - 2'd1].last = 1'b1;
    end

    assign o_bundle = i_take ? bnd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MSG_HEAD; r_pos <= '0; r_head <= '0; r_hcnt <= '0;
            r_outer <= '0; r_name <= '0; r_inner <= '0; r_cstart <= '0;
            r_num <= '0; r_ccnt <= '0; r_err <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_head <= n_head; r_hcnt <= n_hcnt;
            r_outer <= n_outer; r_name <= n_name; r_inner <= n_inner;
            r_cstart <= n_cstart; r_num <= n_num; r_ccnt <= n_ccnt; r_err <= n_err;
        end
    end

endmodule

/* hdl/ctpp_queue.sv */
`timescale 1ns / 1ps
// Event queue: writes a bundle of up to four events per cycle, reads one.
module ctpp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctpp_pkg::t_bundle i_bundle,
    output logic              o_room,
    input  logic              i_pop,
    output logic              o_empty,
    output ctpp_pkg::t_event  o_event
);

    localparam int Depth = 16;
    localparam int AW    = $clog2(Depth);

    ctpp_pkg::t_event r_mem [Depth];
    ctpp_pkg::t_event r_out;
    ctpp_pkg::t_event byp_ev;
    logic        byp_hit;
    logic [AW:0] r_wr, r_rd, n_wr, n_rd;
    logic [AW:0] used;
    logic        do_pop;

    assign used    = r_wr - r_rd;
    assign o_empty = (used == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_event = r_out;
    // Room for a full bundle of four
    assign o_room  = (used <= (AW+1)'(Depth - 4));
    assign n_wr    = r_wr + (AW+1)'(i_bundle.count);
    assign n_rd    = r_rd + (AW+1)'(do_pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < i_bundle.count)
                r_mem[r_wr[AW-1:0] + AW'(k)] <= i_bundle.ev[k];
        end
    end

    // Head slot being written this cycle: forward it to the output register
    always_comb begin
        byp_hit = 1'b0;
        byp_ev  = i_bundle.ev[0];
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < i_bundle.count
                && (r_wr[AW-1:0] + AW'(k)) == n_rd[AW-1:0]) begin
                byp_hit = 1'b1;
                byp_ev  = i_bundle.ev[k];
            end
        end
    end

    // Registered read of the next head entry
    always_ff @(posedge i_clk) begin
        if (byp_hit) begin
            r_out <= byp_ev;
        end else begin
            r_out <= r_mem[n_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

endmodule

/* hdl/ccnx_tlv_packet_parser_top.sv */
`timescale 1ns / 1ps
// CCNx TLV packet parser. Takes one packet byte per cycle while full is low
// (after the fixed header) and posts name, component, chunk, last-chunk, payload
// and verdict events to an output queue, oldest first; each byte is parsed in the
// cycle it is accepted, while the 16-entry event queue keeps room for a full
// four-event bundle. full rises when fewer than four queue entries are free.
// Configuration registers are written with i_cfg_we / i_cfg_addr / i_cfg_wdata.
module ccnx_tlv_packet_parser_top #(
    parameter int MAX_COMPONENTS = ctpp_pkg::MaxComponentsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic [4:0]  o_item_index,
    output logic [15:0] o_item_offset,
    output logic [15:0] o_item_length,
    output logic [31:0] o_number_value,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    ctpp_pkg::t_cfg    r_cfg;
    ctpp_pkg::t_bundle bundle;
    ctpp_pkg::t_event  ev;
    logic room, take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hdr_len: 8'd8, name_code: 16'd0, meta_code: 16'd1,
                       payload_code: 16'd2, segment_code: 16'd1, chunk_code: 16'd16,
                       endchunk_code: 16'd25};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ctpp_pkg::REG_HDR_LEN:  r_cfg.hdr_len       <= i_cfg_wdata[7:0];
                ctpp_pkg::REG_NAME:     r_cfg.name_code     <= i_cfg_wdata;
                ctpp_pkg::REG_META:     r_cfg.meta_code     <= i_cfg_wdata;
                ctpp_pkg::REG_PAYLOAD:  r_cfg.payload_code  <= i_cfg_wdata;
                ctpp_pkg::REG_SEGMENT:  r_cfg.segment_code  <= i_cfg_wdata;
                ctpp_pkg::REG_CHUNK:    r_cfg.chunk_code    <= i_cfg_wdata;
                ctpp_pkg::REG_ENDCHUNK: r_cfg.endchunk_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign full = !room;
    assign take = push && room;

    ctpp_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_byte(i_data_byte),
        .i_eop(i_end_of_packet), .i_cfg(r_cfg), .o_bundle(bundle)
    );

    ctpp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bundle(bundle), .o_room(room),
        .i_pop(pop), .o_empty(empty), .o_event(ev)
    );

    assign o_event_kind   = ev.kind;
    assign o_item_index   = ev.index;
    assign o_item_offset  = ev.offset;
    assign o_item_length  = ev.length;
    assign o_number_value = ev.number;
    assign o_last_of_run  = ev.last;

endmodule
